>>> src/frame_stream_verifier_core_macros.svh
// Assertion macros used by the frame stream verifier RTL.
`ifndef FRAME_STREAM_VERIFIER_CORE_MACROS_SVH
`define FRAME_STREAM_VERIFIER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FSV_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("frame_stream_verifier_core: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FSV_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("frame_stream_verifier_core: next-cycle check failed");
`else
`define FSV_ASSERT_IMP(label, cond, prop)
`define FSV_ASSERT_NXT(label, cond, prop)
`endif
`endif

>>> src/fsv_pkg.sv
// Types, constants and helpers for the frame stream verifier.
package fsv_pkg;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_HEAD0    = 3'd1,
        ERR_HEAD1    = 3'd2,
        ERR_LENGTH   = 3'd3,
        ERR_PLUS     = 3'd4,
        ERR_HASH     = 3'd5,
        ERR_CHECKSUM = 3'd6,
        ERR_SIZE     = 3'd7
    } err_code_t;

    typedef logic [7:0] byte_t;
    typedef logic [8:0] pos_t;

    localparam byte_t CHAR_PLUS  = 8'h2B;
    localparam byte_t CHAR_HASH  = 8'h23;
    localparam byte_t CHAR_UPPER_A = 8'h41;
    localparam byte_t CHAR_UPPER_Z = 8'h5A;
    localparam byte_t CHAR_DIGIT_0 = 8'h30;
    localparam byte_t CHAR_DIGIT_9 = 8'h39;

    // Frame overhead: header(2), length, id, '+', '#', checksum.
    localparam pos_t FRAME_OVERHEAD = 9'd7;
    localparam pos_t POS_MAX        = 9'd256;
    // Last position of a frame that still has a legal size (count 255).
    localparam pos_t POS_LAST_MAX   = 9'd254;
    localparam pos_t POS_LAST_MIN   = FRAME_OVERHEAD - 9'd1;

    localparam pos_t POS_HEAD0 = 9'd0;
    localparam pos_t POS_HEAD1 = 9'd1;
    localparam pos_t POS_LEN   = 9'd2;
    localparam pos_t POS_ID    = 9'd3;
    localparam pos_t POS_PLUS  = 9'd4;

    function automatic logic is_header_char(input byte_t b);
        return ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ||
               ((b >= CHAR_DIGIT_0) && (b <= CHAR_DIGIT_9));
    endfunction

endpackage

>>> src/frame_stream_verifier_core.sv
// Frame stream verifier: byte-serial frame checker with XOR checksum.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   in      | in_valid / in_ready  | byte_value, last_byte
//   out     | out_valid / out_ready| frame_ok, error_code, header_first,
//           |                      | header_second, frame_number, length_field
//
// One beat per cycle, sustained: a byte is first held in the input register,
// then updates the running state as it leaves; the last byte of a frame loads
// the result register as it leaves the input register, which raises out_valid.
// Only a last byte waits on the output side: it holds in the input register
// while an earlier result is still untaken, and that backs up in_ready.
// rst_n (asynchronous, active low) clears all frame state and both valids.
`include "frame_stream_verifier_core_macros.svh"

module frame_stream_verifier_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fsv_pkg::byte_t      byte_value,
    input  logic                last_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                frame_ok,
    output fsv_pkg::err_code_t  error_code,
    output fsv_pkg::byte_t      header_first,
    output fsv_pkg::byte_t      header_second,
    output fsv_pkg::byte_t      frame_number,
    output fsv_pkg::byte_t      length_field
);
    import fsv_pkg::*;

    // Input register stage.
    logic       s1_valid_reg, s1_valid_next;
    byte_t      s1_byte_reg;
    logic       s1_last_reg;

    // Running frame state.
    pos_t       pos_reg, pos_next;
    byte_t      xor_reg, xor_next;
    byte_t      prev_reg, prev_next;
    byte_t      hf_reg, hf_next;
    byte_t      hs_reg, hs_next;
    byte_t      id_reg, id_next;
    byte_t      len_reg, len_next;
    err_code_t  ferr_reg, ferr_next;

    // Result register.
    logic       out_valid_reg, out_valid_next;
    logic       ok_reg;
    err_code_t  code_reg;
    byte_t      rhf_reg, rhs_reg, rid_reg, rlen_reg;

    logic       out_free;
    logic       s1_advance;
    logic       in_fire;
    logic       res_load;
    logic       hdr_bad;
    err_code_t  code_calc;
    byte_t      len_expect;

    // A result slot is free when empty or being drained this cycle.
    assign out_free   = !out_valid_reg || out_ready;
    // Non-last bytes never need the result slot; a last byte waits for it.
    assign s1_advance = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;
    assign res_load   = s1_advance && s1_last_reg;

    assign hdr_bad    = !is_header_char(s1_byte_reg);
    // Length byte must equal (count - 7) mod 256, count = position + 1.
    assign len_expect = pos_reg[7:0] - POS_LAST_MIN[7:0];

    always_comb
    begin
        s1_valid_next = in_fire ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);

        // Capture the header, length and id bytes at their positions.
        hf_next   = (pos_reg == POS_HEAD0) ? s1_byte_reg : hf_reg;
        hs_next   = (pos_reg == POS_HEAD1) ? s1_byte_reg : hs_reg;
        len_next  = (pos_reg == POS_LEN)   ? s1_byte_reg : len_reg;
        id_next   = (pos_reg == POS_ID)    ? s1_byte_reg : id_reg;

        // Keep the first failure among the per-byte checks.
        ferr_next = ferr_reg;
        if (ferr_reg == ERR_NONE)
        begin
            if ((pos_reg == POS_HEAD0) && hdr_bad)
                ferr_next = ERR_HEAD0;
            else if ((pos_reg == POS_HEAD1) && hdr_bad)
                ferr_next = ERR_HEAD1;
            else if ((pos_reg == POS_PLUS) && (s1_byte_reg != CHAR_PLUS))
                ferr_next = ERR_PLUS;
        end

        // End-of-frame verdict, first failing check wins.
        priority if ((pos_reg < POS_LAST_MIN) || (pos_reg > POS_LAST_MAX))
            code_calc = ERR_SIZE;
        else if ((ferr_next == ERR_HEAD0) || (ferr_next == ERR_HEAD1))
            code_calc = ferr_next;
        else if (len_next != len_expect)
            code_calc = ERR_LENGTH;
        else if (ferr_next == ERR_PLUS)
            code_calc = ERR_PLUS;
        else if (prev_reg != CHAR_HASH)
            code_calc = ERR_HASH;
        else if (xor_reg != s1_byte_reg)
            code_calc = ERR_CHECKSUM;
        else
            code_calc = ERR_NONE;

        xor_next  = xor_reg ^ s1_byte_reg;
        prev_next = s1_byte_reg;
        pos_next  = (pos_reg < POS_MAX) ? (pos_reg + 9'd1) : pos_reg;

        out_valid_next = res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // Input register: take a beat whenever the stage is free or moving on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= byte_value;
            s1_last_reg <= last_byte;
        end
    end

    // Frame state: advance on every byte, clear after the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            xor_reg  <= '0;
            prev_reg <= '0;
            hf_reg   <= '0;
            hs_reg   <= '0;
            id_reg   <= '0;
            len_reg  <= '0;
            ferr_reg <= ERR_NONE;
        end
        else if (s1_advance)
        begin
            if (s1_last_reg)
            begin
                pos_reg  <= '0;
                xor_reg  <= '0;
                prev_reg <= '0;
                hf_reg   <= '0;
                hs_reg   <= '0;
                id_reg   <= '0;
                len_reg  <= '0;
                ferr_reg <= ERR_NONE;
            end
            else
            begin
                pos_reg  <= pos_next;
                xor_reg  <= xor_next;
                prev_reg <= prev_next;
                hf_reg   <= hf_next;
                hs_reg   <= hs_next;
                id_reg   <= id_next;
                len_reg  <= len_next;
                ferr_reg <= ferr_next;
            end
        end
    end

    // Result register: load on the last byte, hold until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            ok_reg   <= (code_calc == ERR_NONE);
            code_reg <= code_calc;
            rhf_reg  <= hf_next;
            rhs_reg  <= hs_next;
            rid_reg  <= id_next;
            rlen_reg <= len_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_ok      = ok_reg;
    assign error_code    = code_reg;
    assign header_first  = rhf_reg;
    assign header_second = rhs_reg;
    assign frame_number  = rid_reg;
    assign length_field  = rlen_reg;

    `FSV_ASSERT_IMP(a_pos_bound, 1'b1, pos_reg <= POS_MAX)
    `FSV_ASSERT_NXT(a_clear_after_last, res_load, (pos_reg == '0) && (ferr_reg == ERR_NONE))
    `FSV_ASSERT_NXT(a_pos_step, s1_advance && !s1_last_reg && (pos_reg < POS_MAX), pos_reg == $past(pos_reg) + 9'd1)
    `FSV_ASSERT_IMP(a_ok_matches_code, out_valid_reg, ok_reg == (code_reg == ERR_NONE))

endmodule

>>> test/tb_frame_stream_verifier_core.sv
// Testbench for the frame stream verifier core: framed stimulus, predictor and result checks.
module tb_frame_stream_verifier_core;

    import fsv_pkg::*;

    // Generous bound: about 730 beats, each with at most one random send gap
    // and one random result stall, plus the drain pauses between tests.
    localparam int CYCLE_LIMIT     = 300000;
    localparam int RANDOM_BEATS    = 50;
    // Drop all idling once this many random beats have gone out.
    localparam int QUIET_AFTER     = 30;
    localparam int REPORT_LIMIT    = 10;
    // Idle slack once every verdict has come back.
    localparam int SETTLE_CYCLES   = 6;
    localparam int MAX_PAYLOAD_LEN = 248;

    // Ways to damage a well-formed frame.
    typedef enum int {
        BRK_HEAD0,
        BRK_HEAD1,
        BRK_LENGTH,
        BRK_PLUS,
        BRK_HASH,
        BRK_CHECKSUM
    } break_kind_t;

    typedef struct packed {
        logic      ok;
        err_code_t code;
        byte_t     head0;
        byte_t     head1;
        byte_t     id;
        byte_t     len;
    } frame_verdict_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    byte_t     byte_value;
    logic      last_byte;
    logic      out_valid;
    logic      out_ready;
    logic      frame_ok;
    err_code_t error_code;
    byte_t     header_first;
    byte_t     header_second;
    byte_t     frame_number;
    byte_t     length_field;

    frame_stream_verifier_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_value    (byte_value),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_ok      (frame_ok),
        .error_code    (error_code),
        .header_first  (header_first),
        .header_second (header_second),
        .frame_number  (frame_number),
        .length_field  (length_field)
    );

    // ---------------------------------------------------------------------
    // Clock, cycle guard and shared bookkeeping
    // ---------------------------------------------------------------------
    frame_verdict_t expected_verdicts[$];
    byte_t          frame_buf[$];
    int             mismatch_count;
    int             cycle_count;
    int             random_beats;
    int             stall_left;
    bit             allow_idle;
    frame_verdict_t oldest_verdict;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // End the run if it hangs; a healthy run stays far below the limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Frame predictor: its own copy of the running frame state
    // ---------------------------------------------------------------------
    pos_t      seen_pos;
    byte_t     xor_run;
    byte_t     prev_b;
    byte_t     kept_head0;
    byte_t     kept_head1;
    byte_t     kept_id;
    byte_t     kept_len;
    err_code_t early_err;

    function automatic void clear_frame_state();
        seen_pos   = '0;
        xor_run    = '0;
        prev_b     = '0;
        kept_head0 = '0;
        kept_head1 = '0;
        kept_id    = '0;
        kept_len   = '0;
        early_err  = ERR_NONE;
    endfunction

    function automatic logic header_char_ok(byte_t b);
        return (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
               (b >= CHAR_DIGIT_0 && b <= CHAR_DIGIT_9);
    endfunction

    function automatic void keep_first_err(err_code_t code);
        if (early_err == ERR_NONE)
            early_err = code;
    endfunction

    // Fold one accepted beat into the frame state; on the last byte queue
    // the verdict the block must report, then start a fresh frame.
    function automatic void track_frame_byte(byte_t b, logic is_last);
        err_code_t      code;
        frame_verdict_t v;
        case (seen_pos)
            POS_HEAD0:
            begin
                kept_head0 = b;
                if (!header_char_ok(b))
                    keep_first_err(ERR_HEAD0);
            end
            POS_HEAD1:
            begin
                kept_head1 = b;
                if (!header_char_ok(b))
                    keep_first_err(ERR_HEAD1);
            end
            POS_LEN:  kept_len = b;
            POS_ID:   kept_id = b;
            POS_PLUS:
            begin
                if (b != CHAR_PLUS)
                    keep_first_err(ERR_PLUS);
            end
            default: ;
        endcase

        if (!is_last)
        begin
            xor_run ^= b;
            prev_b = b;
            if (seen_pos < POS_MAX)
                seen_pos++;
            return;
        end

        // Size is judged on the last byte's position; a saturated count
        // always lands above the legal range.
        if (seen_pos < POS_LAST_MIN || seen_pos > POS_LAST_MAX)
            code = ERR_SIZE;
        else if (early_err == ERR_HEAD0 || early_err == ERR_HEAD1)
            code = early_err;
        else if (kept_len != byte_t'(seen_pos + 9'd1 - FRAME_OVERHEAD))
            code = ERR_LENGTH;
        else if (early_err == ERR_PLUS)
            code = ERR_PLUS;
        else if (prev_b != CHAR_HASH)
            code = ERR_HASH;
        else if (xor_run != b)
            code = ERR_CHECKSUM;
        else
            code = ERR_NONE;

        v.ok    = (code == ERR_NONE);
        v.code  = code;
        v.head0 = kept_head0;
        v.head1 = kept_head1;
        v.id    = kept_id;
        v.len   = kept_len;
        expected_verdicts.push_back(v);
        clear_frame_state();
    endfunction

    // ---------------------------------------------------------------------
    // Result side: random stall bursts on out_ready, check every beat
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (allow_idle && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 8);
        if (allow_idle && stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Compare each taken result with the oldest pending verdict.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: ok=%0d code=%0d h=%02h %02h id=%02h len=%02h",
                             frame_ok, error_code, header_first, header_second,
                             frame_number, length_field);
            end
            else
            begin
                oldest_verdict = expected_verdicts.pop_front();
                if (frame_ok !== oldest_verdict.ok || error_code !== oldest_verdict.code ||
                    header_first !== oldest_verdict.head0 ||
                    header_second !== oldest_verdict.head1 ||
                    frame_number !== oldest_verdict.id ||
                    length_field !== oldest_verdict.len)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"mismatch: expected ok=%0d code=%0d h=%02h %02h id=%02h",
                                  " len=%02h, got ok=%0d code=%0d h=%02h %02h id=%02h",
                                  " len=%02h"},
                                 oldest_verdict.ok, oldest_verdict.code,
                                 oldest_verdict.head0, oldest_verdict.head1,
                                 oldest_verdict.id, oldest_verdict.len,
                                 frame_ok, error_code, header_first, header_second,
                                 frame_number, length_field);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Send side
    // ---------------------------------------------------------------------

    // Drive one beat, with an occasional idle burst ahead of it; hold the
    // payload until the handshake, then feed the predictor.
    task automatic send_beat(input byte_t b, input logic is_last);
        int gap;
        if (allow_idle && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        byte_value <= b;
        last_byte  <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_frame_byte(b, is_last);
    endtask

    // Send the frame held in frame_buf; the final byte carries the last flag.
    task automatic send_frame_buf();
        for (int i = 0; i < frame_buf.size(); i++)
            send_beat(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // Pause the sender until every verdict has come back, then settle.
    task automatic wait_for_verdicts();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Frame builders
    // ---------------------------------------------------------------------
    function automatic byte_t pick_header_char();
        int v;
        v = $urandom_range(0, 35);
        return (v < 10) ? byte_t'(CHAR_DIGIT_0 + v) : byte_t'(CHAR_UPPER_A + v - 10);
    endfunction

    function automatic byte_t pick_bad_header_char();
        byte_t b;
        b = byte_t'($urandom_range(0, 255));
        while (header_char_ok(b))
            b = byte_t'($urandom_range(0, 255));
        return b;
    endfunction

    // Pick any byte except the one given.
    function automatic byte_t pick_other(byte_t avoid_b);
        return avoid_b ^ byte_t'($urandom_range(1, 255));
    endfunction

    // Recompute the checksum byte over everything before it.
    function automatic void seal_frame();
        byte_t x;
        x = '0;
        for (int i = 0; i < frame_buf.size() - 1; i++)
            x ^= frame_buf[i];
        frame_buf[frame_buf.size() - 1] = x;
    endfunction

    // Build a well-formed frame with random content around payload_len bytes.
    function automatic void build_frame(int payload_len);
        frame_buf.delete();
        frame_buf.push_back(pick_header_char());
        frame_buf.push_back(pick_header_char());
        frame_buf.push_back(byte_t'(payload_len));
        frame_buf.push_back(byte_t'($urandom_range(0, 255)));
        frame_buf.push_back(CHAR_PLUS);
        for (int i = 0; i < payload_len; i++)
            frame_buf.push_back(byte_t'($urandom_range(0, 255)));
        frame_buf.push_back(CHAR_HASH);
        frame_buf.push_back('0);
        seal_frame();
    endfunction

    // Damage one check of the frame; keep the checksum right unless the
    // checksum itself is the target.
    function automatic void break_frame(break_kind_t kind);
        int n;
        n = frame_buf.size();
        case (kind)
            BRK_HEAD0:    frame_buf[0] = pick_bad_header_char();
            BRK_HEAD1:    frame_buf[1] = pick_bad_header_char();
            BRK_LENGTH:   frame_buf[2] = pick_other(frame_buf[2]);
            BRK_PLUS:     frame_buf[4] = pick_other(CHAR_PLUS);
            BRK_HASH:     frame_buf[n - 2] = pick_other(CHAR_HASH);
            default: ;
        endcase
        seal_frame();
        if (kind == BRK_CHECKSUM)
            frame_buf[n - 1] = pick_other(frame_buf[n - 1]);
    endfunction

    // Fill frame_buf with count random bytes, no structure at all.
    function automatic void build_noise(int count);
        frame_buf.delete();
        for (int i = 0; i < count; i++)
            frame_buf.push_back(byte_t'($urandom_range(0, 255)));
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Clean frames: smallest and largest legal size, header character
    // boundaries, and data at all-zero and all-one.
    task automatic test_good_frames();
        build_frame(0);
        send_frame_buf();
        build_frame(MAX_PAYLOAD_LEN);
        send_frame_buf();
        build_frame(3);
        frame_buf[0] = CHAR_UPPER_A;
        frame_buf[1] = CHAR_UPPER_Z;
        frame_buf[5] = 8'h00;
        frame_buf[6] = 8'hFF;
        frame_buf[7] = 8'h00;
        seal_frame();
        send_frame_buf();
        build_frame(2);
        frame_buf[0] = CHAR_DIGIT_0;
        frame_buf[1] = CHAR_DIGIT_9;
        frame_buf[3] = 8'hFF;
        frame_buf[5] = 8'hFF;
        frame_buf[6] = 8'hFF;
        seal_frame();
        send_frame_buf();
        wait_for_verdicts();
    endtask

    // Header bytes just outside the letter and digit ranges, plus both
    // headers bad at once so the first one wins.
    task automatic test_header_checks();
        byte_t edge_chars[4];
        edge_chars = '{8'h2F, 8'h3A, 8'h40, 8'h5B};
        foreach (edge_chars[i])
        begin
            build_frame(1);
            frame_buf[i % 2] = edge_chars[i];
            seal_frame();
            send_frame_buf();
        end
        build_frame(1);
        frame_buf[0] = 8'hFF;
        frame_buf[1] = 8'h00;
        seal_frame();
        send_frame_buf();
        wait_for_verdicts();
    endtask

    // Each field check alone, then pairs that exercise the reporting order.
    task automatic test_field_checks();
        build_frame(4);
        break_frame(BRK_LENGTH);
        send_frame_buf();
        build_frame(4);
        break_frame(BRK_PLUS);
        send_frame_buf();
        build_frame(4);
        break_frame(BRK_HASH);
        send_frame_buf();
        build_frame(4);
        break_frame(BRK_CHECKSUM);
        send_frame_buf();
        // Length outranks plus, plus outranks hash, header outranks length.
        build_frame(2);
        break_frame(BRK_PLUS);
        break_frame(BRK_LENGTH);
        send_frame_buf();
        build_frame(2);
        break_frame(BRK_HASH);
        break_frame(BRK_PLUS);
        send_frame_buf();
        build_frame(2);
        break_frame(BRK_LENGTH);
        break_frame(BRK_HEAD1);
        send_frame_buf();
        wait_for_verdicts();
    endtask

    // Frames too short or too long; short ones report unreceived fields as zero.
    task automatic test_size_limits();
        build_noise(1);
        send_frame_buf();
        build_noise(3);
        send_frame_buf();
        // Six bytes: well formed up to the missing checksum.
        build_frame(0);
        void'(frame_buf.pop_back());
        frame_buf[5] = CHAR_HASH;
        send_frame_buf();
        // Over the legal size and long enough to saturate the byte position.
        build_frame(MAX_PAYLOAD_LEN + 3);
        send_frame_buf();
        wait_for_verdicts();
    endtask

    // Mostly clean frames with random content, some broken, some noise;
    // the tail runs with no idling on either side.
    task automatic test_random_frames();
        int pick;
        int payload_len;
        while (random_beats < RANDOM_BEATS)
        begin
            if (random_beats >= QUIET_AFTER)
                allow_idle = 1'b0;
            payload_len = ($urandom_range(0, 49) == 0) ? $urandom_range(30, 60)
                                                       : $urandom_range(0, 20);
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                build_frame(payload_len);
            end
            else if (pick < 88)
            begin
                build_frame(payload_len);
                break_frame(break_kind_t'($urandom_range(BRK_HEAD0, BRK_CHECKSUM)));
                if ($urandom_range(0, 3) == 0)
                    break_frame(break_kind_t'($urandom_range(BRK_HEAD0, BRK_CHECKSUM)));
            end
            else
            begin
                build_noise($urandom_range(1, 12));
            end
            random_beats += frame_buf.size();
            send_frame_buf();
        end
        wait_for_verdicts();
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        byte_value     <= '0;
        last_byte      <= 1'b0;
        out_ready      <= 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        random_beats   = 0;
        stall_left     = 0;
        allow_idle     = 1'b1;
        clear_frame_state();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_good_frames();
        test_header_checks();
        test_field_checks();
        test_size_limits();
        test_random_frames();

        if (mismatch_count == 0 && expected_verdicts.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
